FILE: design/fqc_pkg.sv
// ----------------------------------------------------------------------------
// fqc_pkg
// Shared types and constants for the fp32 quantize/convert pipeline.
// ----------------------------------------------------------------------------
package fqc_pkg;

  typedef enum logic [2:0] {
    FMT_INT8   = 3'd0,
    FMT_UINT8  = 3'd1,
    FMT_INT16  = 3'd2,
    FMT_UINT16 = 3'd3,
    FMT_BF16   = 3'd4
  } fmt_e;

  typedef enum logic [1:0] {
    REG_TARGET_FORMAT = 2'd0,
    REG_QUANT_SCALE   = 2'd1,
    REG_ZERO_OFFSET   = 2'd2,
    REG_BF16_ROUND    = 2'd3
  } reg_idx_e;

  localparam logic [31:0] FP32_ONE    = 32'h3f80_0000;
  localparam logic [15:0] BF16_MAXFIN = 16'h7f7f;
  localparam logic [15:0] BF16_EXPMSK = 16'h7f80;
  localparam logic [15:0] BF16_BIAS   = 16'h7fff;
  localparam logic [8:0]  EXP_OFFSET  = 9'd300;  // two biases plus 46 fraction bits
  localparam logic [32:0] MAG_POS_MAX = 33'h0_7fff_ffff;
  localparam logic [32:0] MAG_NEG_MAX = 33'h0_8000_0000;
  localparam logic signed [33:0] S8_MAX = 34'sd127;
  localparam logic signed [33:0] S8_MIN = -34'sd128;
  localparam logic signed [33:0] U8_MAX = 34'sd255;

  // Product stage to normalize stage.
  typedef struct packed {
    logic [47:0] prod;
    logic [8:0]  esum;
    logic        sign;
    logic        is_nan;
    logic        is_inf;
    logic [2:0]  fmt;
    logic [15:0] bf16;
    logic        last;
  } mul_t;

  // Normalize stage to integer stage.
  typedef struct packed {
    logic [24:0]        rnd;
    logic signed [10:0] expo;
    logic               zero;
    logic               sign;
    logic               is_nan;
    logic               is_inf;
    logic [2:0]         fmt;
    logic [15:0]        bf16;
    logic               last;
  } norm_t;

endpackage

FILE: design/fqc_mul.sv
// ----------------------------------------------------------------------------
// fqc_mul
// Mantissa multiply of value and scale, special-operand flags, bf16 result.
// ----------------------------------------------------------------------------
module fqc_mul (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [31:0]    value_i,
  input  logic           last_i,
  input  logic [2:0]     fmt_i,
  input  logic [31:0]    scale_i,
  input  logic           bf16_rnd_i,
  output fqc_pkg::mul_t  mul_o
);
  import fqc_pkg::*;

  logic [31:0] scl;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        nan_a, nan_b, inf_a, inf_b, zer_a, zer_b;
  logic [31:0] u;
  logic [15:0] hi;
  mul_t        mul_d, mul_q;

  // The 16-bit modes round the value itself: multiply by one.
  assign scl = (fmt_i == FMT_INT16 || fmt_i == FMT_UINT16) ? FP32_ONE : scale_i;

  always_comb begin
    ea    = value_i[30:23];
    eb    = scl[30:23];
    ma    = {(ea != 8'd0), value_i[22:0]};
    mb    = {(eb != 8'd0), scl[22:0]};
    nan_a = (ea == 8'hff) && (value_i[22:0] != 23'd0);
    nan_b = (eb == 8'hff) && (scl[22:0] != 23'd0);
    inf_a = (ea == 8'hff) && (value_i[22:0] == 23'd0);
    inf_b = (eb == 8'hff) && (scl[22:0] == 23'd0);
    zer_a = (value_i[30:0] == 31'd0);
    zer_b = (scl[30:0] == 31'd0);

    u = value_i;
    if (bf16_rnd_i) begin
      u = value_i + {16'd0, BF16_BIAS} + {31'd0, value_i[16]};
    end
    hi = u[31:16];
    if ((hi & BF16_EXPMSK) == BF16_EXPMSK) begin
      hi = BF16_MAXFIN;
    end

    mul_d.prod   = 48'(ma) * 48'(mb);
    // Subnormals use exponent one.
    mul_d.esum   = 9'((ea == 8'd0) ? 8'd1 : ea) + 9'((eb == 8'd0) ? 8'd1 : eb);
    mul_d.sign   = value_i[31] ^ scl[31];
    mul_d.is_nan = nan_a || nan_b || (inf_a && zer_b) || (inf_b && zer_a);
    mul_d.is_inf = inf_a || inf_b;
    mul_d.fmt    = fmt_i;
    mul_d.bf16   = hi;
    mul_d.last   = last_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mul_q <= mul_d;
    end
  end

  assign mul_o = mul_q;

endmodule

FILE: design/fqc_norm.sv
// ----------------------------------------------------------------------------
// fqc_norm
// Leading-one search and round-to-nearest-even of the product to 24 bits.
// ----------------------------------------------------------------------------
module fqc_norm (
  input  logic            clk_i,
  input  logic            en_i,
  input  fqc_pkg::mul_t   mul_i,
  output fqc_pkg::norm_t  norm_o
);
  import fqc_pkg::*;

  logic [5:0]  lead;
  logic [47:0] nrm;
  logic [23:0] top;
  logic        grd, stk;
  norm_t       norm_d, norm_q;

  always_comb begin
    lead = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (mul_i.prod[i]) begin
        lead = 6'(i);
      end
    end
    nrm = mul_i.prod << (6'd47 - lead);
    top = nrm[47:24];
    grd = nrm[23];
    stk = |nrm[22:0];

    norm_d.rnd    = {1'b0, top} + {24'd0, grd && (stk || top[0])};
    norm_d.expo   = $signed({5'd0, lead}) + $signed({2'd0, mul_i.esum})
                    - $signed({2'd0, EXP_OFFSET});
    norm_d.zero   = (mul_i.prod == 48'd0);
    norm_d.sign   = mul_i.sign;
    norm_d.is_nan = mul_i.is_nan;
    norm_d.is_inf = mul_i.is_inf;
    norm_d.fmt    = mul_i.fmt;
    norm_d.bf16   = mul_i.bf16;
    norm_d.last   = mul_i.last;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_q <= norm_d;
    end
  end

  assign norm_o = norm_q;

endmodule

FILE: design/fqc_int.sv
// ----------------------------------------------------------------------------
// fqc_int
// Round half away to int32, 8-bit zero point and saturation, format select.
// ----------------------------------------------------------------------------
module fqc_int (
  input  logic                clk_i,
  input  logic                en_i,
  input  fqc_pkg::norm_t      norm_i,
  input  logic signed [15:0]  zero_offset_i,
  output logic [15:0]         converted_o,
  output logic                last_o
);
  import fqc_pkg::*;

  logic [5:0]         sh;
  logic [57:0]        fix;
  logic [32:0]        mag;
  logic signed [33:0] r, rz;
  logic [15:0]        conv_d, conv_q;
  logic               last_q;

  always_comb begin
    sh  = 6'(norm_i.expo + 11'sd2);
    fix = {33'd0, norm_i.rnd} << sh;
    mag = '0;
    if (norm_i.is_nan) begin
      mag = '0;
    end else if (norm_i.is_inf || norm_i.expo >= 11'sd31) begin
      mag = norm_i.sign ? MAG_NEG_MAX : MAG_POS_MAX;
    end else if (norm_i.zero || norm_i.expo < -11'sd2) begin
      mag = '0;
    end else begin
      mag = fix[57:25] + {32'd0, fix[24]};
      if (!norm_i.sign && mag > MAG_POS_MAX) begin
        mag = MAG_POS_MAX;
      end
    end
    r  = norm_i.sign ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    rz = r + 34'(zero_offset_i);

    conv_d = '0;
    unique case (norm_i.fmt)
      FMT_INT8: begin
        if (rz > S8_MAX)      conv_d = {8'd0, 8'(S8_MAX)};
        else if (rz < S8_MIN) conv_d = {8'd0, 8'(S8_MIN)};
        else                  conv_d = {8'd0, rz[7:0]};
      end
      FMT_UINT8: begin
        if (rz > U8_MAX)      conv_d = {8'd0, 8'(U8_MAX)};
        else if (rz < 34'sd0) conv_d = '0;
        else                  conv_d = {8'd0, rz[7:0]};
      end
      FMT_INT16, FMT_UINT16: conv_d = r[15:0];
      FMT_BF16:              conv_d = norm_i.bf16;
      default:               conv_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      conv_q <= conv_d;
      last_q <= norm_i.last;
    end
  end

  assign converted_o = conv_q;
  assign last_o      = last_q;

endmodule

FILE: design/fp32_quantize_convert.sv
// ----------------------------------------------------------------------------
// fp32_quantize_convert
// Streams fp32 values into int8/uint8/int16/uint16/bf16 encodings.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_*: one fp32 value per item in tdata, tlast marks the
//   end of a tensor. Master channel m_axis_*: one result per item, converted
//   in tdata (8-bit modes in the low byte, upper byte zero), tlast copied.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 format, 1 scale, 2 zero point, 3 bf16 rounding); write only when idle.
// Timing:
//   Four-stage pipeline: input register, mantissa multiply, leading-one
//   normalize with round to nearest even, then integer rounding/clamp into
//   the output register, which drives tvalid. Every stage advances together,
//   so throughput is one item per cycle while the output is not stalled.
// Reset:
//   Clears all stage valid bits and loads the registers with format int8,
//   scale 1.0, zero point 0 and bf16 rounding off.
// Stall:
//   When the output holds an item that is not taken, the whole pipeline
//   holds and s_axis_tready drops; bubbles advance while the output is free.
// ----------------------------------------------------------------------------
module fp32_quantize_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value_bits
  input  logic        s_axis_tlast,   // last_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] converted
  output logic        m_axis_tlast,   // last_out
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import fqc_pkg::*;

  logic [2:0]  fmt_q;
  logic [31:0] scale_q;
  logic [15:0] zp_q;
  logic        bf_rnd_q;
  logic        en;
  logic        in_v_q, mul_v_q, norm_v_q, out_v_q;
  logic [31:0] val_q;
  logic        last_q;
  mul_t        mul_s;
  norm_t       norm_s;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_INT8;
      scale_q  <= FP32_ONE;
      zp_q     <= '0;
      bf_rnd_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TARGET_FORMAT: fmt_q    <= cfg_data_i[2:0];
        REG_QUANT_SCALE:   scale_q  <= cfg_data_i;
        REG_ZERO_OFFSET:   zp_q     <= cfg_data_i[15:0];
        REG_BF16_ROUND:    bf_rnd_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Advance every stage unless the output item is held.
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      mul_v_q  <= 1'b0;
      norm_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else if (en) begin
      in_v_q   <= s_axis_tvalid;
      mul_v_q  <= in_v_q;
      norm_v_q <= mul_v_q;
      out_v_q  <= norm_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q  <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  fqc_mul u_mul (
    .clk_i,
    .en_i       (en),
    .value_i    (val_q),
    .last_i     (last_q),
    .fmt_i      (fmt_q),
    .scale_i    (scale_q),
    .bf16_rnd_i (bf_rnd_q),
    .mul_o      (mul_s)
  );

  fqc_norm u_norm (
    .clk_i,
    .en_i   (en),
    .mul_i  (mul_s),
    .norm_o (norm_s)
  );

  fqc_int u_int (
    .clk_i,
    .en_i          (en),
    .norm_i        (norm_s),
    .zero_offset_i ($signed(zp_q)),
    .converted_o   (m_axis_tdata),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tvalid = out_v_q;

  // An accepted item lands in the input register.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> in_v_q)
    else $error("accepted item not captured");

  // A full middle stage reaches the output when the pipeline moves.
  a_norm_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_v_q && en |=> m_axis_tvalid)
    else $error("item lost between normalize and output");

  // Ready only falls while a result waits at the output.
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> m_axis_tvalid && !m_axis_tready)
    else $error("ready dropped without a held result");

endmodule
